[sv/texture_slot_batch_binder_macros.svh]
// assertion helpers for the texture slot batch binder, clocked on clock, off in reset
`ifndef TEXTURE_SLOT_BATCH_BINDER_MACROS_SVH
`define TEXTURE_SLOT_BATCH_BINDER_MACROS_SVH

// same-cycle implication
`define TSB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsb check failed");

// next-cycle implication
`define TSB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsb check failed");

`endif

[sv/tsb_pkg.sv]
`default_nettype none

package tsb_pkg;

   localparam int QUAD_LIMIT = 8192;
   localparam int SLOT_COUNT = 32;

   localparam int ACTION_W = 2;
   localparam int HANDLE_W = 32;
   localparam int SLOT_W   = 5;
   localparam int USED_W   = 6;
   localparam int QUAD_W   = 14;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN  = 2'd0,
      ACT_DRAW   = 2'd1,
      ACT_END    = 2'd2,
      ACT_UNUSED = 2'd3
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [HANDLE_W-1:0] texture_handle;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              flushed;
      logic [QUAD_W-1:0] flush_quads;
      logic [USED_W-1:0] flush_slots;
   } rsp_item_type;

   // match result handed from cell to cell along the row
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } chain_type;

endpackage

`default_nettype wire

[sv/texture_slot_batch_binder.sv]
// Texture slot batch binder. An item is accepted when start is high and busy is low;
// every item gives exactly one result, on rsp_item for one cycle with rsp_strobe high,
// and the receiver cannot stall it. Busy is set in the cycle after each accepted
// item, so the block takes no new item while one is in progress: the first step
// compares the handle in all slot cells at once and registers the match, the second
// walks the match along the cell row, updates the slot and quad counts and writes a new
// handle into its cell. Slot 0 is the white texture and has no cell.
`default_nettype none

module texture_slot_batch_binder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire tsb_pkg::req_item_type req_item,
   output logic                       rsp_strobe,
   output tsb_pkg::rsp_item_type      rsp_item
);

   localparam int NCELL = tsb_pkg::SLOT_COUNT;

   logic                           busy_ff;
   logic                           rsp_strobe_ff;
   tsb_pkg::rsp_item_type          rsp_item_ff, rsp_item_in;
   tsb_pkg::req_item_type          req_ff;
   logic [tsb_pkg::USED_W-1:0]     used_ff, used_in;
   logic [tsb_pkg::QUAD_W-1:0]     quads_ff, quads_in;

   logic                           accept;
   logic                           wr_valid;
   logic [tsb_pkg::SLOT_W-1:0]     wr_slot;
   tsb_pkg::chain_type             chain [NCELL];

   logic                           batch_full;
   logic                           found;
   logic [tsb_pkg::USED_W-1:0]     used_a, used_b;
   logic [tsb_pkg::QUAD_W-1:0]     quads_a, quads_b;

   assign accept     = start && !busy_ff;
   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign chain[0] = '0;

   for (genvar i = 1; i < NCELL; i++) begin : g_cell
      tsb_slot_cell u_cell (
         .clock      (clock),
         .cell_index (tsb_pkg::SLOT_W'(i)),
         .slots_used (used_ff),
         .cmp_en     (accept),
         .key        (req_item.texture_handle),
         .wr_valid   (wr_valid),
         .wr_slot    (wr_slot),
         .wr_data    (req_ff.texture_handle),
         .chain_in   (chain[i-1]),
         .chain_out  (chain[i])
      );
   end

   always_comb begin
      used_in     = used_ff;
      quads_in    = quads_ff;
      rsp_item_in = '0;
      wr_valid    = 1'b0;
      batch_full  = quads_ff >= tsb_pkg::QUAD_W'(tsb_pkg::QUAD_LIMIT);
      // a full batch restarts first, which also voids any match
      used_a      = batch_full ? tsb_pkg::USED_W'(1) : used_ff;
      quads_a     = batch_full ? '0 : quads_ff;
      found       = chain[NCELL-1].found && !batch_full;
      used_b      = used_a;
      quads_b     = quads_a;
      wr_slot     = tsb_pkg::SLOT_W'(used_b);

      unique case (tsb_pkg::action_type'(req_ff.action))
         tsb_pkg::ACT_BEGIN: begin
            used_in  = tsb_pkg::USED_W'(1);
            quads_in = '0;
         end
         tsb_pkg::ACT_END: begin
            if (quads_ff != '0) begin
               rsp_item_in.flushed     = 1'b1;
               rsp_item_in.flush_quads = quads_ff;
               rsp_item_in.flush_slots = used_ff;
            end
         end
         tsb_pkg::ACT_DRAW: begin
            if (batch_full) begin
               rsp_item_in.flushed     = 1'b1;
               rsp_item_in.flush_quads = quads_ff;
               rsp_item_in.flush_slots = used_ff;
            end
            if (found) begin
               rsp_item_in.slot_index = chain[NCELL-1].slot;
            end else begin
               // table full: flush and put the handle in slot 1
               if (used_a >= tsb_pkg::USED_W'(tsb_pkg::SLOT_COUNT)) begin
                  if (quads_a != '0) begin
                     rsp_item_in.flushed     = 1'b1;
                     rsp_item_in.flush_quads = quads_a;
                     rsp_item_in.flush_slots = used_a;
                  end
                  used_b  = tsb_pkg::USED_W'(1);
                  quads_b = '0;
               end
               wr_slot                = tsb_pkg::SLOT_W'(used_b);
               wr_valid               = busy_ff;
               rsp_item_in.slot_index = wr_slot;
               used_b                 = used_b + tsb_pkg::USED_W'(1);
            end
            used_in  = used_b;
            quads_in = quads_b + tsb_pkg::QUAD_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         used_ff       <= tsb_pkg::USED_W'(1);
         quads_ff      <= '0;
      end else begin
         busy_ff       <= accept;
         rsp_strobe_ff <= busy_ff;
         if (busy_ff) begin
            used_ff  <= used_in;
            quads_ff <= quads_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (busy_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

`default_nettype wire

[sv/tsb_slot_cell.sv]
`default_nettype none

module tsb_slot_cell (
   input  wire logic                       clock,
   input  wire logic [tsb_pkg::SLOT_W-1:0] cell_index,
   input  wire logic [tsb_pkg::USED_W-1:0] slots_used,
   input  wire logic                       cmp_en,
   input  wire logic [tsb_pkg::HANDLE_W-1:0] key,
   input  wire logic                       wr_valid,
   input  wire logic [tsb_pkg::SLOT_W-1:0] wr_slot,
   input  wire logic [tsb_pkg::HANDLE_W-1:0] wr_data,
   input  wire tsb_pkg::chain_type         chain_in,
   output tsb_pkg::chain_type              chain_out
);

   logic [tsb_pkg::HANDLE_W-1:0] handle_ff;
   logic                         match_ff;
   logic                         match_in;

   // only slots below the fill count hold handles of the current batch
   assign match_in = (handle_ff == key) && ({1'b0, cell_index} < slots_used);

   always_ff @(posedge clock) begin
      if (wr_valid && (wr_slot == cell_index)) begin
         handle_ff <= wr_data;
      end
      if (cmp_en) begin
         match_ff <= match_in;
      end
   end

   // handles are unique within a batch, so at most one cell matches
   always_comb begin
      chain_out.found = chain_in.found | match_ff;
      chain_out.slot  = chain_in.slot | (match_ff ? cell_index : '0);
   end

endmodule

`default_nettype wire

[sv/tsb_checker.sv]
`default_nettype none

`include "texture_slot_batch_binder_macros.svh"

module tsb_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_strobe,
   input wire tsb_pkg::rsp_item_type rsp_item
);

   logic counts_zero;
   logic counts_set;

   assign counts_zero = (rsp_item.flush_quads == '0) && (rsp_item.flush_slots == '0);
   assign counts_set  = (rsp_item.flush_quads != '0) && (rsp_item.flush_slots != '0);

   `TSB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `TSB_ASSERT_NEXT(a_busy_result, busy, rsp_strobe && !busy)
   `TSB_ASSERT_NOW(a_result_from_busy, rsp_strobe, $past(busy))
   `TSB_ASSERT_NOW(a_no_flush_zero, rsp_strobe && !rsp_item.flushed, counts_zero)
   `TSB_ASSERT_NOW(a_flush_nonempty, rsp_strobe && rsp_item.flushed, counts_set)

endmodule

bind texture_slot_batch_binder tsb_checker u_tsb_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
